// ===== hdl/msma_pkg.sv =====
// Package of the multi-sensor moving average unit: sizes, codes and the
// per-sensor bookkeeping record. No dependencies.
package msma_pkg;

  localparam int SENSOR_COUNT = 4;
  localparam int WINDOW_DEPTH = 8;

  localparam int SAMPLE_W    = 32;
  localparam int SENSOR_ID_W = 3;
  localparam int STATUS_W    = 2;
  localparam int TOTAL_W     = 16;

  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_DEPTH);
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int ID_W   = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

  localparam int WIN_DEPTH = SENSOR_COUNT * WINDOW_DEPTH;
  localparam int WIN_AW    = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_EMPTY  = 2'd1,
    STATUS_BAD_ID = 2'd2
  } status_e;

  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    sum_t              sum;
    logic [SLOT_W-1:0] slot;
  } meta_t;

endpackage

// ===== hdl/msma_if.sv =====
// Valid/ready channel interfaces for the input items and the results.
// Depends on msma_pkg for the field widths.
interface msma_in_if;
  import msma_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [SENSOR_ID_W-1:0]        sensor_id;
  logic signed [SAMPLE_W-1:0]    sample;

  modport source (output valid, output op, output sensor_id, output sample, input ready);
  modport sink   (input valid, input op, input sensor_id, input sample, output ready);
endinterface

interface msma_out_if;
  import msma_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_W-1:0]    average;
  logic [STATUS_W-1:0]           status;
  logic [TOTAL_W-1:0]            sample_total;

  modport source (output valid, output average, output status, output sample_total,
                  input ready);
  modport sink   (input valid, input average, input status, input sample_total,
                  output ready);
endinterface

// ===== hdl/msma_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module msma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/multi_sensor_moving_average_unit.sv =====
// Top level of the multi-sensor moving average unit.
// Depends on msma_pkg, the channel interfaces in msma_if and msma_ram.
//
// Usage. Items arrive on item_i as valid/ready transactions. A record
// transaction (op 0) stores a sample in the rolling window of its sensor and
// returns nothing; a read transaction (op 1) returns one result transaction on
// result_o with the rolling average, a status and the running sample count.
// Sensor ids at or above the sensor count are ignored on record and answered
// with average -1 and a bad-id status on read; an empty sensor reads 0.
//
// Sequencing. The unit works on one item at a time and is ready again once
// the item has finished. A record reads the sensor's bookkeeping entry, then
// reads the window slot to be evicted, then writes both memories back. A read
// of a sensor with samples takes its average from a restoring divider that
// retires one quotient bit per cycle over the full width of the running sum.
// A read of an empty or invalid sensor skips the divider. Invalid records
// finish in the cycle they are accepted.
//
// Reset clears the bookkeeping valid bits, the sample count and all control
// state at once, so there is no clearing pass. The window memory is not
// cleared: a slot's value is used only once it has been written. A result
// waits in an output register while the receiver stalls; the next item is
// still accepted, and its own result waits until that register is free.
module multi_sensor_moving_average_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  msma_in_if.sink     item_i,
  msma_out_if.source  result_o
);
  import msma_pkg::*;

  localparam int CNT_W     = $clog2(SUM_W);
  localparam int ID_CMP_W  = SENSOR_ID_W + 1;
  localparam int META_W    = $bits(meta_t);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_META = 3'd1;
  localparam logic [2:0] ST_WIN  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_RES  = 3'd4;

  logic [2:0] state_q, state_d;

  // Item held for the duration of its processing.
  logic                       op_q;
  logic [SENSOR_ID_W-1:0]     id_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  meta_t                      meta_q;
  logic [WIN_AW-1:0]          win_addr_q, win_addr_d;

  // Divider state: the dividend register shifts out magnitude bits and
  // collects quotient bits from the bottom.
  logic [SUM_W-1:0]  dvd_q, dvd_d;
  logic [FILL_W-1:0] rem_q, rem_d;
  logic [FILL_W-1:0] div_n_q;
  logic              neg_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              from_div_q, from_div_d;

  logic signed [SAMPLE_W-1:0] res_avg_q, res_avg_d;
  status_e                    res_status_q, res_status_d;

  logic [TOTAL_W-1:0] acc_q, acc_d;

  logic                       out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] out_avg_q;
  logic [STATUS_W-1:0]        out_status_q;
  logic [TOTAL_W-1:0]         out_total_q;
  logic                       out_load;

  logic [SENSOR_COUNT-1:0] meta_vld_q;
  logic                    meta_rd_vld_q;

  // Memory ports.
  logic              meta_re, meta_we;
  logic [ID_W-1:0]   meta_raddr;
  logic [META_W-1:0] meta_rdata;
  meta_t             meta_rd, meta_wr;
  logic              win_re, win_we;
  logic [WIN_AW-1:0] win_raddr;
  logic [SAMPLE_W-1:0] win_rdata;

  logic item_acc, id_ok;
  logic latch_item, latch_meta, start_div;

  // Window arithmetic.
  logic       win_full;
  sum_t       evicted, sum_new, sum_mag;
  logic [FILL_W:0] trial;
  logic            trial_ge;
  logic [SUM_W-1:0] quo_signed;

  assign item_i.ready = (state_q == ST_IDLE);
  assign item_acc     = item_i.valid && item_i.ready;
  assign id_ok        = {1'b0, item_i.sensor_id} < ID_CMP_W'(SENSOR_COUNT);

  assign out_load = (state_q == ST_RES) && (!out_valid_q || result_o.ready);

  // An entry that was never written reads as the reset value of zero.
  assign meta_rd = meta_rd_vld_q ? meta_t'(meta_rdata) : '0;

  assign win_full = (meta_q.fill == FILL_W'(WINDOW_DEPTH));
  assign evicted  = win_full ? sum_t'($signed(win_rdata)) : '0;
  assign sum_new  = meta_q.sum - evicted + sum_t'(sample_q);

  assign sum_mag  = meta_rd.sum[SUM_W-1] ? -meta_rd.sum : meta_rd.sum;

  assign trial    = {rem_q, dvd_q[SUM_W-1]};
  assign trial_ge = trial >= {1'b0, div_n_q};

  assign quo_signed = neg_q ? -dvd_q : dvd_q;

  always_comb begin
    state_d      = state_q;
    latch_item   = 1'b0;
    latch_meta   = 1'b0;
    start_div    = 1'b0;
    meta_re      = 1'b0;
    meta_raddr   = item_i.sensor_id[ID_W-1:0];
    meta_we      = 1'b0;
    meta_wr      = meta_q;
    win_re       = 1'b0;
    win_we       = 1'b0;
    win_raddr    = WIN_AW'(id_q) * WIN_AW'(WINDOW_DEPTH) + WIN_AW'(meta_rd.slot);
    win_addr_d   = win_addr_q;
    dvd_d        = dvd_q;
    rem_d        = rem_q;
    cnt_d        = cnt_q;
    from_div_d   = from_div_q;
    res_avg_d    = res_avg_q;
    res_status_d = res_status_q;
    acc_d        = acc_q;

    unique case (state_q)
      ST_IDLE: begin
        if (item_acc) begin
          latch_item = 1'b1;
          if (id_ok) begin
            meta_re = 1'b1;
            state_d = ST_META;
          end else if (item_i.op == OP_READ) begin
            res_avg_d    = -32'sd1;
            res_status_d = STATUS_BAD_ID;
            from_div_d   = 1'b0;
            state_d      = ST_RES;
          end
        end
      end
      ST_META: begin
        latch_meta = 1'b1;
        if (op_q == OP_RECORD) begin
          win_re     = 1'b1;
          win_addr_d = win_raddr;
          state_d    = ST_WIN;
        end else if (meta_rd.fill == '0) begin
          res_avg_d    = '0;
          res_status_d = STATUS_EMPTY;
          from_div_d   = 1'b0;
          state_d      = ST_RES;
        end else begin
          // The fill level saturates at the window depth, so it is the
          // divisor as it stands.
          start_div  = 1'b1;
          dvd_d      = sum_mag;
          rem_d      = '0;
          cnt_d      = CNT_W'(SUM_W - 1);
          from_div_d = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_WIN: begin
        win_we       = 1'b1;
        meta_we      = 1'b1;
        meta_wr.sum  = sum_new;
        meta_wr.fill = win_full ? meta_q.fill : meta_q.fill + 1'b1;
        meta_wr.slot = (meta_q.slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0
                                                                 : meta_q.slot + 1'b1;
        acc_d        = acc_q + 1'b1;
        state_d      = ST_IDLE;
      end
      ST_DIV: begin
        rem_d = trial_ge ? FILL_W'(trial - {1'b0, div_n_q}) : trial[FILL_W-1:0];
        dvd_d = {dvd_q[SUM_W-2:0], trial_ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          res_status_d = STATUS_OK;
          state_d      = ST_RES;
        end
      end
      ST_RES: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      acc_q         <= '0;
      out_valid_q   <= 1'b0;
      meta_vld_q    <= '0;
      meta_rd_vld_q <= 1'b0;
      cnt_q         <= '0;
      from_div_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      from_div_q  <= from_div_d;
      if (meta_re) begin
        meta_rd_vld_q <= meta_vld_q[meta_raddr];
      end
      if (meta_we) begin
        meta_vld_q[id_q[ID_W-1:0]] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (latch_item) begin
      op_q     <= item_i.op;
      id_q     <= item_i.sensor_id;
      sample_q <= item_i.sample;
    end
    if (latch_meta) begin
      meta_q <= meta_rd;
    end
    if (start_div) begin
      div_n_q <= meta_rd.fill;
      neg_q   <= meta_rd.sum[SUM_W-1];
    end
    win_addr_q   <= win_addr_d;
    dvd_q        <= dvd_d;
    rem_q        <= rem_d;
    res_avg_q    <= res_avg_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_avg_q    <= from_div_q ? $signed(quo_signed[SAMPLE_W-1:0]) : res_avg_q;
      out_status_q <= res_status_q;
      out_total_q  <= acc_q;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.average      = out_avg_q;
  assign result_o.status       = out_status_q;
  assign result_o.sample_total = out_total_q;

  // Per-sensor fill level, running sum and write slot.
  msma_ram #(
    .WIDTH (META_W),
    .DEPTH (SENSOR_COUNT)
  ) u_meta_ram (
    .clk_i     (clk_i),
    .wr_en_i   (meta_we),
    .wr_addr_i (id_q[ID_W-1:0]),
    .wr_data_i (META_W'(meta_wr)),
    .rd_en_i   (meta_re),
    .rd_addr_i (meta_raddr),
    .rd_data_o (meta_rdata)
  );

  // Sample windows of all sensors, one row of WINDOW_DEPTH slots per sensor.
  msma_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WIN_DEPTH)
  ) u_win_ram (
    .clk_i     (clk_i),
    .wr_en_i   (win_we),
    .wr_addr_i (win_addr_q),
    .wr_data_i (sample_q),
    .rd_en_i   (win_re),
    .rd_addr_i (win_raddr),
    .rd_data_o (win_rdata)
  );

  // The fill level written back never passes the window depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    meta_we |-> (meta_wr.fill <= FILL_W'(WINDOW_DEPTH)))
    else $error("fill level written beyond the window depth");

  // The sample count moves only when a sample is written to a window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_q != $past(acc_q)) |-> $past(win_we))
    else $error("sample count changed without a stored sample");

  // The divider never runs with a zero divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_n_q != '0))
    else $error("division by a zero fill level");

  // A result only appears out of the result state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RES))
    else $error("result presented outside the result state");

endmodule

// ===== tb/multi_sensor_moving_average_unit_tb.sv =====
// Testbench of the multi-sensor moving average unit: directed and random item
// transactions, each read result checked field by field against a predictor.
// Depends on msma_pkg, the channel interfaces in msma_if and the unit itself.
module multi_sensor_moving_average_unit_tb;
  import msma_pkg::*;

  // The cycle limit sits well above the slowest correct run: about eleven
  // hundred items, each at worst a read behind the longest gaps on both
  // sides, plus one long receiver hold-off.
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned LAST_ID      = (1 << SENSOR_ID_W) - 1;

  // One expected read result, in the order the reads were accepted.
  typedef struct {
    logic signed [SAMPLE_W-1:0] average;
    status_e                    status;
    logic [TOTAL_W-1:0]         total;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  msma_in_if  item_if ();
  msma_out_if result_if ();

  multi_sensor_moving_average_unit u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if)
  );

  always #10 clk_i = ~clk_i;

  // Predicted state of every sensor: its window of samples, how full it is,
  // the sum of what it holds and the slot that the next sample goes to.
  logic signed [SAMPLE_W-1:0] window_copy [SENSOR_COUNT][WINDOW_DEPTH] = '{default: '0};
  int unsigned                fill_copy   [SENSOR_COUNT] = '{default: 0};
  longint                     sum_copy    [SENSOR_COUNT] = '{default: 0};
  int unsigned                slot_copy   [SENSOR_COUNT] = '{default: 0};
  logic [TOTAL_W-1:0]         samples_seen = '0;

  reading_t    pending_readings [$];
  int unsigned error_count     = 0;
  int unsigned cycle_count     = 0;
  bit          idling_on       = 1'b1;
  // The stimulus asks for a long receiver hold-off by raising the request
  // count; the receiver notices the difference and counts the hold itself.
  int unsigned holds_requested = 0;
  int unsigned holds_served    = 0;

  // Gap lengths for both sides: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Samples lean on the extremes and on small values of either sign, so that
  // sums cancel as well as pile up, with plenty of fully random words too.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      4, 5, 6: return $urandom_range(0, 2000) - 1000;
      default: return $urandom();
    endcase
  endfunction

  // Applies one accepted item to the predicted state. A record with a valid
  // id updates its sensor and the sample count; a read queues the result it
  // should give. A record with an invalid id changes nothing at all.
  function automatic void predict_average(logic op, logic [SENSOR_ID_W-1:0] id,
                                          logic signed [SAMPLE_W-1:0] smp);
    reading_t    reading;
    int unsigned s;
    if (op == OP_RECORD) begin
      if (id < SENSOR_COUNT) begin
        s = slot_copy[id];
        // Only a full window gives up its oldest sample, so the slot being
        // overwritten has always been written before.
        if (fill_copy[id] >= WINDOW_DEPTH) sum_copy[id] -= window_copy[id][s];
        window_copy[id][s] = smp;
        sum_copy[id]      += smp;
        slot_copy[id]      = (s + 1) % WINDOW_DEPTH;
        if (fill_copy[id] < WINDOW_DEPTH) fill_copy[id]++;
        samples_seen++;
      end
    end else begin
      reading.total = samples_seen;
      if (id >= SENSOR_COUNT) begin
        reading.average = -1;
        reading.status  = STATUS_BAD_ID;
      end else if (fill_copy[id] == 0) begin
        reading.average = '0;
        reading.status  = STATUS_EMPTY;
      end else begin
        // Signed integer division truncates toward zero, as the unit must.
        reading.average = SAMPLE_W'(sum_copy[id] / longint'(fill_copy[id]));
        reading.status  = STATUS_OK;
      end
      pending_readings.push_back(reading);
    end
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    $display("cycle %0d: mismatch in %s: expected %0d, got %0d",
             cycle_count, what, want, got);
    error_count++;
  endtask

  // Offers one item and waits until the transaction completes. A gap, if
  // any, lowers valid first; with no gap, valid simply stays high from the
  // previous transaction, so it is never lowered and raised in one step.
  task automatic send_item(logic op, logic [SENSOR_ID_W-1:0] id,
                           logic signed [SAMPLE_W-1:0] smp);
    int unsigned gap;
    gap = idling_on ? pick_gap() : 0;
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid     <= 1'b1;
    item_if.op        <= op;
    item_if.sensor_id <= id;
    item_if.sample    <= smp;
    do @(posedge clk_i); while (!item_if.ready);
    predict_average(op, id, smp);
  endtask

  // Short directed run over the corner cases: empty and invalid sensors,
  // ignored records, the window filling past its depth, both extremes of the
  // sample range and truncation of a negative average toward zero.
  task automatic test_directed_cases();
    send_item(OP_READ, 3'd0, '0);
    send_item(OP_READ, 3'd7, 32'sh5A5A_5A5A);
    send_item(OP_RECORD, 3'd5, 32'sh1234_5678);
    send_item(OP_RECORD, 3'd4, '1);
    send_item(OP_READ, 3'd4, '0);
    // Nine maximal samples: the fill level saturates and the oldest is
    // evicted, and the widened sum must not overflow.
    repeat (WINDOW_DEPTH + 1) send_item(OP_RECORD, 3'd1, 32'sh7FFF_FFFF);
    send_item(OP_READ, 3'd1, '0);
    send_item(OP_RECORD, 3'd2, 32'sh8000_0000);
    send_item(OP_READ, 3'd2, '0);
    // Minus three over two samples must give minus one, not minus two.
    send_item(OP_RECORD, 3'd3, -3);
    send_item(OP_RECORD, 3'd3, '0);
    send_item(OP_READ, 3'd3, '0);
    send_item(OP_RECORD, 3'd0, 32'sd5);
    send_item(OP_READ, 3'd0, '0);
  endtask

  // Random mix of records and reads, mostly to valid sensors so that windows
  // fill, wrap and evict many times over. Every fourth block of a hundred
  // items runs with no idling on either side.
  task automatic test_random_traffic(int unsigned count);
    logic                   op;
    logic [SENSOR_ID_W-1:0] id;
    for (int unsigned n = 0; n < count; n++) begin
      idling_on = ((n / 100) % 4) != 3;
      op = ($urandom_range(0, 99) < 35) ? OP_READ : OP_RECORD;
      if ($urandom_range(0, 9) == 0)
        id = SENSOR_ID_W'($urandom_range(SENSOR_COUNT, LAST_ID));
      else
        id = SENSOR_ID_W'($urandom_range(0, SENSOR_COUNT - 1));
      send_item(op, id, pick_sample());
    end
    idling_on = 1'b1;
  endtask

  // The receiver holds off for a long stretch while items keep coming, so
  // the output register fills and the unit has to stall its input.
  task automatic test_output_backpressure();
    idling_on = 1'b0;
    holds_requested++;
    for (int unsigned n = 0; n < 12; n++)
      send_item((n % 3 == 2) ? OP_RECORD : OP_READ, SENSOR_ID_W'(n % (LAST_ID + 1)),
                pick_sample());
    idling_on = 1'b1;
  endtask

  // Receiver: random stalls while idling is on, and the long hold-off when
  // one is requested. The ready value is worked out first and then driven
  // once per clock edge.
  initial begin : result_receiver
    int unsigned stall_left;
    int unsigned hold_left;
    logic        take;
    stall_left = 0;
    hold_left  = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_served != holds_requested) begin
        holds_served = holds_requested;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        take = 1'b0;
      end else begin
        stall_left = idling_on ? pick_gap() : 0;
        take       = (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
      result_if.ready <= take;
    end
  end

  // Every result transaction is matched against the oldest expected reading.
  // Values are sampled just after the edge, before any of them change.
  always @(posedge clk_i) begin : check_results
    reading_t oldest;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected result, average", longint'(0),
                        longint'(result_if.average));
      end else begin
        oldest = pending_readings.pop_front();
        if (result_if.average !== oldest.average)
          report_mismatch("average", longint'(oldest.average),
                          longint'(result_if.average));
        if (result_if.status !== oldest.status)
          report_mismatch("status", longint'(oldest.status),
                          longint'(result_if.status));
        if (result_if.sample_total !== oldest.total)
          report_mismatch("sample_total", longint'(oldest.total),
                          longint'(result_if.sample_total));
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding",
             cycle_count, pending_readings.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    item_if.valid     <= 1'b0;
    item_if.op        <= OP_RECORD;
    item_if.sensor_id <= '0;
    item_if.sample    <= '0;
    rst_ni            <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_random_traffic(RANDOM_ITEMS);
    test_output_backpressure();
    test_random_traffic(80);

    // All items are in; let the outstanding reads come back and then give
    // the unit a little longer than its slowest read to show anything stray.
    item_if.valid <= 1'b0;
    wait (pending_readings.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
